/* rtl/core/ede_pkg.sv */
// shared types and constants for the edit distance engine
package ede_pkg;

    localparam int MAX_LEN_DEF = 64;
    localparam int SYM_W       = 8;
    localparam int OP_W        = 2;
    localparam int DIST_OUT_W  = 7;
    localparam int DIST_SAT    = 127;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_TARGET = 2'd1,
        OP_FINISH = 2'd2
    } ede_op_t;

    typedef struct packed {
        ede_op_t          op;
        logic [SYM_W-1:0] symbol;
    } ede_cmd_t;

    typedef struct packed {
        logic [DIST_OUT_W-1:0] distance;
        logic                  error;
    } ede_result_t;

    typedef struct packed {
        logic             load;
        logic             clear;
        logic [SYM_W-1:0] symbol;
    } ede_ctrl_t;

endpackage

/* rtl/core/ede_cell.sv */
// one cell of the distance row: a source symbol and its column distance
module ede_cell #(
    parameter int INDEX  = 1,
    parameter int DIST_W = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ede_pkg::ede_ctrl_t  ctrl,
    input  logic                prev_loaded,
    output logic                loaded,
    input  logic                tok_in,
    input  logic [DIST_W-1:0]   left_in,
    input  logic [DIST_W-1:0]   diag_in,
    output logic                tok_out,
    output logic [DIST_W-1:0]   left_out,
    output logic [DIST_W-1:0]   diag_out
);

    logic [ede_pkg::SYM_W-1:0] sym_reg;
    logic                      loaded_reg, loaded_next;
    logic [DIST_W-1:0]         dist_reg, dist_next;
    logic                      tok_reg, tok_next;
    logic [DIST_W-1:0]         left_reg, left_next;
    logic [DIST_W-1:0]         diag_reg, diag_next;
    logic                      load_here;
    logic [DIST_W-1:0]         min_a;
    logic [DIST_W-1:0]         min_b;
    logic [DIST_W-1:0]         cell_val;

    assign load_here = ctrl.load & prev_loaded & ~loaded_reg;

    always_comb
    begin
        min_a    = (left_in < dist_reg) ? left_in : dist_reg;
        min_b    = (min_a < diag_in) ? min_a : diag_in;
        cell_val = (sym_reg == ctrl.symbol) ? diag_in : min_b + DIST_W'(1);
    end

    always_comb
    begin
        dist_next   = dist_reg;
        loaded_next = loaded_reg;
        if (ctrl.clear)
        begin
            dist_next   = DIST_W'(INDEX);
            loaded_next = 1'b0;
        end
        else if (load_here)
        begin
            loaded_next = 1'b1;
        end
        else if (tok_in && loaded_reg)
        begin
            dist_next = cell_val;
        end
        tok_next  = tok_in;
        left_next = loaded_reg ? cell_val : left_in;
        diag_next = dist_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= 1'b0;
            dist_reg   <= DIST_W'(INDEX);
            tok_reg    <= 1'b0;
        end
        else
        begin
            loaded_reg <= loaded_next;
            dist_reg   <= dist_next;
            tok_reg    <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_here)
        begin
            sym_reg <= ctrl.symbol;
        end
        left_reg <= left_next;
        diag_reg <= diag_next;
    end

    assign loaded   = loaded_reg;
    assign tok_out  = tok_reg;
    assign left_out = left_reg;
    assign diag_out = diag_reg;

endmodule

/* rtl/core/edit_distance_engine.sv */
// top level: command decode, length tracking and the chain of distance cells
// load and finish items leave busy low, so start is taken again at once
// a target item holds busy high while its update runs down the cell chain
// the result is strobed on result_valid in the cycle after a finish item is taken
// reset, and every finish item, return the row to entry i = i and clear lengths and error
// the receiver cannot stall; each result is shown for exactly one cycle
module edit_distance_engine #(
    parameter int MAX_LEN = ede_pkg::MAX_LEN_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  ede_pkg::ede_cmd_t     cmd,
    output logic                  result_valid,
    output ede_pkg::ede_result_t  result
);

    localparam int DIST_W = $clog2(MAX_LEN + 1);
    localparam int WIDE_W = DIST_W + ede_pkg::DIST_OUT_W + 1;

    logic                       accept;
    ede_pkg::ede_ctrl_t         ctrl;
    logic                       load, clear;

    logic                       busy_reg, busy_next;
    logic [DIST_W-1:0]          slen_reg, slen_next;
    logic [DIST_W-1:0]          tlen_reg, tlen_next;
    logic                       started_reg, started_next;
    logic                       err_reg, err_next;
    logic [DIST_W-1:0]          last_reg, last_next;
    logic [ede_pkg::SYM_W-1:0]  tsym_reg, tsym_next;
    logic                       head_tok_reg, head_tok_next;
    logic [DIST_W-1:0]          head_left_reg, head_left_next;
    logic [DIST_W-1:0]          head_diag_reg, head_diag_next;
    logic                       valid_reg, valid_next;
    ede_pkg::ede_result_t       result_reg, result_next;
    logic [WIDE_W-1:0]          dist_wide;

    logic                       loaded_link [0:MAX_LEN];
    logic                       tok_link    [0:MAX_LEN];
    logic [DIST_W-1:0]          left_link   [0:MAX_LEN];
    logic [DIST_W-1:0]          diag_link   [0:MAX_LEN];

    assign accept = start & ~busy_reg;

    assign ctrl.load   = load;
    assign ctrl.clear  = clear;
    assign ctrl.symbol = busy_reg ? tsym_reg : cmd.symbol;

    assign loaded_link[0] = 1'b1;
    assign tok_link[0]    = head_tok_reg;
    assign left_link[0]   = head_left_reg;
    assign diag_link[0]   = head_diag_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LEN; gi++)
        begin : g_cell
            ede_cell #(
                .INDEX  (gi + 1),
                .DIST_W (DIST_W)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .prev_loaded (loaded_link[gi]),
                .loaded      (loaded_link[gi+1]),
                .tok_in      (tok_link[gi]),
                .left_in     (left_link[gi]),
                .diag_in     (diag_link[gi]),
                .tok_out     (tok_link[gi+1]),
                .left_out    (left_link[gi+1]),
                .diag_out    (diag_link[gi+1])
            );
        end
    endgenerate

    // distance at finish: source length until a target arrives, else the last pass
    assign dist_wide = WIDE_W'((tlen_reg == '0) ? slen_reg : last_reg);

    always_comb
    begin
        busy_next      = busy_reg;
        slen_next      = slen_reg;
        tlen_next      = tlen_reg;
        started_next   = started_reg;
        err_next       = err_reg;
        last_next      = last_reg;
        tsym_next      = tsym_reg;
        head_tok_next  = 1'b0;
        head_left_next = head_left_reg;
        head_diag_next = head_diag_reg;
        valid_next     = 1'b0;
        result_next    = result_reg;
        load           = 1'b0;
        clear          = 1'b0;

        if (tok_link[MAX_LEN])
        begin
            busy_next = 1'b0;
            last_next = left_link[MAX_LEN];
        end

        if (accept)
        begin
            case (cmd.op)
                ede_pkg::OP_LOAD:
                begin
                    if (!err_reg)
                    begin
                        if (started_reg || slen_reg == DIST_W'(MAX_LEN))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            load      = 1'b1;
                            slen_next = slen_reg + DIST_W'(1);
                        end
                    end
                end
                ede_pkg::OP_TARGET:
                begin
                    if (!err_reg)
                    begin
                        started_next = 1'b1;
                        if (tlen_reg == DIST_W'(MAX_LEN))
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            tlen_next      = tlen_reg + DIST_W'(1);
                            head_tok_next  = 1'b1;
                            head_left_next = tlen_reg + DIST_W'(1);
                            head_diag_next = tlen_reg;
                            tsym_next      = cmd.symbol;
                            busy_next      = 1'b1;
                        end
                    end
                end
                ede_pkg::OP_FINISH:
                begin
                    valid_next        = 1'b1;
                    result_next.error = err_reg;
                    if (err_reg)
                    begin
                        result_next.distance = '0;
                    end
                    else if (dist_wide > WIDE_W'(ede_pkg::DIST_SAT))
                    begin
                        result_next.distance = ede_pkg::DIST_OUT_W'(ede_pkg::DIST_SAT);
                    end
                    else
                    begin
                        result_next.distance = dist_wide[ede_pkg::DIST_OUT_W-1:0];
                    end
                    clear        = 1'b1;
                    slen_next    = '0;
                    tlen_next    = '0;
                    started_next = 1'b0;
                    err_next     = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            slen_reg     <= '0;
            tlen_reg     <= '0;
            started_reg  <= 1'b0;
            err_reg      <= 1'b0;
            head_tok_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            slen_reg     <= slen_next;
            tlen_reg     <= tlen_next;
            started_reg  <= started_next;
            err_reg      <= err_next;
            head_tok_reg <= head_tok_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg      <= last_next;
        tsym_reg      <= tsym_next;
        head_left_reg <= head_left_next;
        head_diag_reg <= head_diag_next;
        result_reg    <= result_next;
    end

    assign busy         = busy_reg;
    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

/* sim/tb_top.sv */
// testbench for edit_distance_engine: directed table, random string pairs, scoreboard
`timescale 1ns / 1ps

module tb_top;
    import ede_pkg::*;

    localparam int      LEN_CAP     = MAX_LEN_DEF;
    localparam int      RAND_ITEMS  = 1200;
    localparam int      ANY_SYM     = -1;
    localparam int      REPORT_CAP  = 40;
    localparam ede_op_t OP_SPARE    = ede_op_t'(2'd3);
    localparam int      SCRIPT_ROWS = 27;

    typedef struct {
        ede_op_t     op;
        int          sym;
        int          reps;
        bit          typed;
        ede_result_t want;
    } script_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    ede_cmd_t    cmd = '0;
    logic        busy;
    logic        result_valid;
    ede_result_t result;

    ede_result_t expected_results [$];
    int          fail_count = 0;
    int          idle_pct = 0;

    logic [SYM_W-1:0] src_syms [LEN_CAP];
    logic [6:0]       dist_row [LEN_CAP+1];
    int               src_len;
    int               tgt_len;
    bit               tgt_seen;
    bit               misuse;

    script_row_t script [SCRIPT_ROWS] = '{
        '{OP_FINISH, 0,       1,           1'b1, '{7'd0,  1'b0}},
        '{OP_LOAD,   8'h00,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_LOAD,   8'hFF,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_TARGET, 8'hFF,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_TARGET, 8'h00,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_FINISH, 8'hFF,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_LOAD,   ANY_SYM, LEN_CAP,     1'b0, '{7'd0,  1'b0}},
        '{OP_FINISH, 0,       1,           1'b1, '{7'd64, 1'b0}},
        '{OP_TARGET, ANY_SYM, LEN_CAP,     1'b0, '{7'd0,  1'b0}},
        '{OP_FINISH, 0,       1,           1'b1, '{7'd64, 1'b0}},
        '{OP_LOAD,   ANY_SYM, LEN_CAP + 1, 1'b0, '{7'd0,  1'b0}},
        '{OP_FINISH, 0,       1,           1'b1, '{7'd0,  1'b1}},
        '{OP_TARGET, ANY_SYM, LEN_CAP + 1, 1'b0, '{7'd0,  1'b0}},
        '{OP_FINISH, 0,       1,           1'b1, '{7'd0,  1'b1}},
        '{OP_LOAD,   8'h41,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_TARGET, 8'h41,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_LOAD,   8'h42,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_TARGET, 8'h42,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_FINISH, 0,       1,           1'b1, '{7'd0,  1'b1}},
        '{OP_SPARE,  8'h5A,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_LOAD,   8'h5A,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_SPARE,  8'hA5,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_TARGET, 8'h5A,   1,           1'b0, '{7'd0,  1'b0}},
        '{OP_FINISH, 0,       1,           1'b1, '{7'd0,  1'b0}},
        '{OP_LOAD,   ANY_SYM, LEN_CAP,     1'b0, '{7'd0,  1'b0}},
        '{OP_TARGET, ANY_SYM, LEN_CAP,     1'b0, '{7'd0,  1'b0}},
        '{OP_FINISH, 0,       1,           1'b0, '{7'd0,  1'b0}}
    };

    edit_distance_engine #(
        .MAX_LEN(LEN_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .result_valid(result_valid),
        .result(result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void clear_pair();
        int i;
        for (i = 0; i <= LEN_CAP; i++)
        begin
            dist_row[i] = 7'(i);
        end
        src_len  = 0;
        tgt_len  = 0;
        tgt_seen = 1'b0;
        misuse   = 1'b0;
    endfunction

    function automatic void predict_edit(input ede_cmd_t c, output bit emits,
                                         output ede_result_t res, output bit live);
        logic [6:0] diag;
        logic [6:0] above;
        logic [6:0] m;
        int         d;
        int         i;
        emits = 1'b0;
        res   = '0;
        live  = 1'b0;
        case (c.op)
            OP_LOAD:
            begin
                if (!misuse)
                begin
                    live = 1'b1;
                    if (tgt_seen || src_len >= LEN_CAP)
                    begin
                        misuse = 1'b1;
                    end
                    else
                    begin
                        src_syms[src_len] = c.symbol;
                        src_len++;
                    end
                end
            end
            OP_TARGET:
            begin
                if (!misuse)
                begin
                    live     = 1'b1;
                    tgt_seen = 1'b1;
                    if (tgt_len >= LEN_CAP)
                    begin
                        misuse = 1'b1;
                    end
                    else
                    begin
                        tgt_len++;
                        diag = dist_row[0];
                        dist_row[0] = 7'(tgt_len);
                        for (i = 1; i <= src_len; i++)
                        begin
                            above = dist_row[i];
                            if (src_syms[i-1] == c.symbol)
                            begin
                                dist_row[i] = diag;
                            end
                            else
                            begin
                                m = dist_row[i-1];
                                if (above < m)
                                begin
                                    m = above;
                                end
                                if (diag < m)
                                begin
                                    m = diag;
                                end
                                dist_row[i] = m + 7'd1;
                            end
                            diag = above;
                        end
                    end
                end
            end
            OP_FINISH:
            begin
                live  = 1'b1;
                emits = 1'b1;
                if (misuse)
                begin
                    res.error = 1'b1;
                end
                else
                begin
                    d = dist_row[src_len];
                    res.distance = (d > DIST_SAT) ? 7'(DIST_SAT) : 7'(d);
                end
                clear_pair();
            end
            default:
            begin
            end
        endcase
    endfunction

    task automatic issue(input ede_cmd_t c, input bit typed, input ede_result_t want,
                         output bit live);
        bit          emits;
        ede_result_t res;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        @(posedge clk);
        while (busy !== 1'b0)
        begin
            @(posedge clk);
        end
        predict_edit(c, emits, res, live);
        if (emits)
        begin
            expected_results.push_back(typed ? want : res);
        end
    endtask

    function automatic logic [SYM_W-1:0] pick_sym(input bit narrow, input logic [SYM_W-1:0] base);
        return narrow ? base + SYM_W'($urandom_range(0, 3)) : SYM_W'($urandom);
    endfunction

    function automatic int pick_len();
        if ($urandom_range(0, 9) < 8)
        begin
            return $urandom_range(0, 8);
        end
        return $urandom_range(9, LEN_CAP);
    endfunction

    task automatic feed(input ede_op_t op, input logic [SYM_W-1:0] sym, inout int live_total);
        ede_cmd_t c;
        bit       live;
        if ($urandom_range(0, 99) < 4)
        begin
            c.op     = OP_SPARE;
            c.symbol = SYM_W'($urandom);
            issue(c, 1'b0, '0, live);
        end
        c.op     = op;
        c.symbol = sym;
        issue(c, 1'b0, '0, live);
        if (live)
        begin
            live_total++;
        end
    endtask

    task automatic run_pair(inout int live_total);
        int               kind;
        int               slen;
        int               tlen;
        int               late_at;
        int               i;
        bit               narrow;
        logic [SYM_W-1:0] base;
        kind    = $urandom_range(0, 99);
        narrow  = ($urandom_range(0, 1) == 1);
        base    = SYM_W'($urandom);
        slen    = pick_len();
        tlen    = pick_len();
        late_at = -1;
        if (kind >= 96)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                slen = LEN_CAP + 1;
            end
            else
            begin
                tlen = LEN_CAP + 1;
            end
        end
        else if (kind >= 86)
        begin
            if (tlen == 0)
            begin
                tlen = 1;
            end
            late_at = $urandom_range(0, tlen - 1);
        end
        for (i = 0; i < slen; i++)
        begin
            feed(OP_LOAD, pick_sym(narrow, base), live_total);
        end
        for (i = 0; i < tlen; i++)
        begin
            feed(OP_TARGET, pick_sym(narrow, base), live_total);
            if (i == late_at)
            begin
                feed(OP_LOAD, pick_sym(narrow, base), live_total);
            end
        end
        feed(OP_FINISH, SYM_W'($urandom), live_total);
    endtask

    always @(posedge clk)
    begin : result_check
        ede_result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_CAP)
                begin
                    $error("unexpected result: distance %0d error %0b",
                           result.distance, result.error);
                end
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.distance !== want.distance)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                    begin
                        $error("distance: expected %0d, actual %0d",
                               want.distance, result.distance);
                    end
                end
                if (result.error !== want.error)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_CAP)
                    begin
                        $error("error: expected %0b, actual %0b", want.error, result.error);
                    end
                end
            end
        end
    end

    initial
    begin
        #12_000_000;
        $display("tb_top: errors");
        $finish;
    end

    initial
    begin : stimulus
        int       sender_idle [4];
        int       r;
        int       k;
        int       p;
        int       live_total;
        bit       live;
        ede_cmd_t c;
        sender_idle = '{0, 50, 0, 35};
        live_total  = 0;
        clear_pair();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < SCRIPT_ROWS; r++)
        begin
            for (k = 0; k < script[r].reps; k++)
            begin
                c.op     = script[r].op;
                c.symbol = (script[r].sym == ANY_SYM) ? SYM_W'($urandom) : SYM_W'(script[r].sym);
                issue(c, script[r].typed, script[r].want, live);
            end
        end

        for (p = 0; p < 4; p++)
        begin
            start <= 1'b0;
            @(posedge clk);
            while (expected_results.size() != 0)
            begin
                @(posedge clk);
            end
            idle_pct = sender_idle[p];
            while (live_total < (p + 1) * RAND_ITEMS / 4)
            begin
                run_pair(live_total);
            end
        end

        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LEN_CAP + 4) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/ede_pkg.sv
rtl/core/ede_cell.sv
rtl/core/edit_distance_engine.sv
sim/tb_top.sv
